// ===== hdl/nst_pkg.sv =====
// Shared types and codes for the named semaphore table.
// Used by the controller, the datapath and the top level.
package nst_pkg;

  localparam logic [1:0] KIND_OPEN   = 2'd0;
  localparam logic [1:0] KIND_WAIT   = 2'd1;
  localparam logic [1:0] KIND_POST   = 2'd2;
  localparam logic [1:0] KIND_UNLINK = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
  localparam logic [2:0] ST_BAD_NAME   = 3'd4;

  localparam int CNT_W = 17;
  localparam logic signed [CNT_W-1:0] COUNT_MIN = -17'sd65536;
  localparam logic signed [CNT_W-1:0] COUNT_MAX = 17'sd65535;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_SCAN   = 5'b00100,
    S_COMMIT = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic scan_start;
    logic scan_step;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } sts_t;

endpackage

// ===== hdl/nst_ram.sv =====
// Generic single-port-write RAM with a registered read.
// No dependencies.
module nst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/nst_ctrl.sv =====
// Controller state machine of the named semaphore table.
// Depends on nst_pkg.
module nst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  nst_pkg::sts_t sts,
  output nst_pkg::cmd_t cmd
);
  import nst_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = valid;
        if (valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        cmd.scan_start = sts.need_scan;
        state_next = sts.need_scan ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> state == S_SCAN)
    else $error("scan not entered");
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not shown after commit");
endmodule

// ===== hdl/nst_dp.sv =====
// Datapath: name table, counts, waiter lists and result registers.
// Depends on nst_pkg and nst_ram.
module nst_dp #(
  parameter int SLOTS       = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int NAME_BYTES  = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  nst_pkg::cmd_t       cmd,
  output nst_pkg::sts_t       sts,
  input  logic [1:0]          kind,
  input  logic [63:0]         name_word,
  input  logic [3:0]          sem_slot,
  input  logic [5:0]          task_id,
  input  logic [15:0]         initial_value,
  output logic [3:0]          slot_out,
  output logic [2:0]          status,
  output logic                caller_blocks,
  output logic                wake_valid,
  output logic [5:0]          wake_task,
  output logic signed [16:0]  count_now
);
  import nst_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int TW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = SW + QW;

  // Latched request.
  logic [1:0]  r_kind;
  logic [63:0] r_name;
  logic [3:0]  r_slot;
  logic [5:0]  r_task;
  logic [15:0] r_init;
  logic        r_name_ok;

  logic [63:0]         names [SLOTS];
  logic signed [CNT_W-1:0] counts [SLOTS];
  logic [TW-1:0]       totals [SLOTS];

  // Canonical name and its validity.
  logic [63:0] canon;
  logic        canon_ok;
  always_comb begin
    logic stop;
    logic bad;
    canon = '0;
    stop = 1'b0;
    bad = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (name_word[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) begin
        if (i >= NAME_BYTES) bad = 1'b1;
        canon[8*i +: 8] = name_word[8*i +: 8];
      end
    end
    canon_ok = !bad && (canon != '0);
  end

  // Lookup over the table: matching slot and lowest free slot.
  logic          hit, free_any;
  logic [SW-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0; free_any = 1'b0; hit_idx = '0; free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (names[i] != '0 && names[i] == r_name) begin
        hit = 1'b1; hit_idx = SW'(i);
      end
      if (names[i] == '0) begin
        free_any = 1'b1; free_idx = SW'(i);
      end
    end
  end

  logic          slot_ok;
  logic [SW-1:0] ws;
  assign slot_ok = ({28'd0, r_slot} < 32'(SLOTS)) && (names[ws] != '0);
  assign ws = r_slot[SW-1:0];

  // Working values for wait and post.
  logic signed [CNT_W-1:0] c_cur;
  logic [TW-1:0]           tot;
  assign c_cur = counts[ws];
  assign tot = totals[ws];

  // Queue RAM: scan through it one entry a cycle.
  logic          q_we;
  logic [AW-1:0] q_waddr, q_raddr;
  logic [5:0]    q_wdata, q_rdata;
  logic [TW-1:0] scan_i;     // index being read
  logic          scan_rv;    // q_rdata valid for index scan_i-1
  logic          listed;
  logic [5:0]    head;

  nst_ram #(.WIDTH(6), .DEPTH(1 << AW)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  logic [QW-1:0] rd_q;
  assign rd_q = (r_kind != KIND_POST) ? scan_i[QW-1:0] :
                (scan_i == TW'(0)) ? QW'(tot - TW'(1)) : QW'(0);
  assign q_raddr = {ws, rd_q};

  logic is_sem;
  assign is_sem = (r_kind == KIND_WAIT) || (r_kind == KIND_POST);
  logic signed [CNT_W-1:0] nc_wait, nc_post;
  assign nc_wait = (c_cur > COUNT_MIN) ? c_cur - 17'sd1 : c_cur;
  assign nc_post = (c_cur < COUNT_MAX) ? c_cur + 17'sd1 : c_cur;

  // Wait scans all listed entries; post reads the last then entry 0.
  logic scan_len_zero;
  assign scan_len_zero = (tot == '0);
  assign sts.need_scan = is_sem && slot_ok && !scan_len_zero &&
                         ((r_kind == KIND_WAIT && nc_wait < 0) ||
                          (r_kind == KIND_POST && nc_post <= 0));
  logic [TW-1:0] last_rd;
  assign last_rd = (r_kind == KIND_POST) ? TW'(1) : tot - TW'(1);
  assign sts.scan_done = scan_rv && (scan_i == last_rd + TW'(1)) ||
                         (scan_rv && r_kind == KIND_POST && scan_i == TW'(2));

  logic [5:0] tail;
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_rv <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_i <= (r_kind == KIND_POST) ? TW'(0) : TW'(0);
      scan_rv <= 1'b0;
      listed <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_done) scan_i <= scan_i + TW'(1);
      scan_rv <= 1'b1;
      if (scan_rv) begin
        if (r_kind == KIND_WAIT && q_rdata == r_task) listed <= 1'b1;
        if (r_kind == KIND_POST && scan_i == TW'(1)) tail <= q_rdata;
        if (r_kind == KIND_POST && scan_i == TW'(2)) head <= q_rdata;
      end
    end
  end

  // On the post path the first read targets the tail, the second entry 0.

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) names[i] <= '0;
    end else begin
      if (cmd.load) begin
        r_kind <= kind; r_name <= canon; r_name_ok <= canon_ok;
        r_slot <= sem_slot; r_task <= task_id; r_init <= initial_value;
      end
      if (cmd.commit) begin
        slot_out <= '0; status <= ST_OK; caller_blocks <= 1'b0;
        wake_valid <= 1'b0; wake_task <= '0; count_now <= '0;
        if (r_kind == KIND_OPEN || r_kind == KIND_UNLINK) begin
          if (!r_name_ok) status <= ST_BAD_NAME;
          else if (r_kind == KIND_OPEN) begin
            if (hit) begin
              slot_out <= 4'(hit_idx); count_now <= counts[hit_idx];
            end else if (!free_any) status <= ST_TABLE_FULL;
            else begin
              names[free_idx] <= r_name;
              counts[free_idx] <= CNT_W'({1'b0, r_init});
              totals[free_idx] <= '0;
              slot_out <= 4'(free_idx);
              count_now <= CNT_W'({1'b0, r_init});
            end
          end else if (!hit) status <= ST_NOT_FOUND;
          else begin
            names[hit_idx] <= '0; slot_out <= 4'(hit_idx);
          end
        end else if (!slot_ok) begin
          status <= ST_NOT_FOUND; slot_out <= r_slot;
        end else begin
          slot_out <= r_slot;
          count_now <= c_cur;
          if (r_kind == KIND_WAIT) begin
            if (nc_wait >= 0) begin
              counts[ws] <= nc_wait; count_now <= nc_wait;
            end else if (!scan_len_zero && listed) begin
              counts[ws] <= nc_wait; count_now <= nc_wait; caller_blocks <= 1'b1;
            end else if (tot >= TW'(QUEUE_DEPTH)) begin
              status <= ST_QUEUE_FULL;
            end else begin
              totals[ws] <= tot + TW'(1);
              counts[ws] <= nc_wait; count_now <= nc_wait; caller_blocks <= 1'b1;
            end
          end else begin
            counts[ws] <= nc_post; count_now <= nc_post;
            if (nc_post <= 0 && !scan_len_zero) begin
              wake_valid <= 1'b1; wake_task <= head;
              totals[ws] <= tot - TW'(1);
            end
          end
        end
      end
    end
  end

  // Queue writes at commit: append on wait, move tail to head on post.
  always_comb begin
    q_we = 1'b0; q_waddr = {ws, QW'(0)}; q_wdata = r_task;
    if (cmd.commit && is_sem && slot_ok) begin
      if (r_kind == KIND_WAIT && nc_wait < 0 && !(listed && !scan_len_zero)
          && tot < TW'(QUEUE_DEPTH)) begin
        q_we = 1'b1; q_waddr = {ws, tot[QW-1:0]}; q_wdata = r_task;
      end else if (r_kind == KIND_POST && nc_post <= 0 && !scan_len_zero) begin
        q_we = 1'b1; q_waddr = {ws, QW'(0)}; q_wdata = tail;
      end
    end
  end

  a_tot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && is_sem && slot_ok |-> tot <= TW'(QUEUE_DEPTH))
    else $error("waiter total out of range");
  a_wake_post: assert property (@(posedge clk) disable iff (rst)
    $rose(wake_valid) |-> $past(r_kind) == KIND_POST)
    else $error("wake outside post");
  a_block_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(caller_blocks) |-> $past(r_kind) == KIND_WAIT)
    else $error("block outside wait");
endmodule

// ===== hdl/named_semaphore_table_core.sv =====
// Top level of the named semaphore table: controller plus datapath.
// Depends on nst_pkg, nst_ctrl, nst_dp and nst_ram.
//
// One request at a time. Open, unlink and requests that need no waiter list
// pass from lookup straight to commit; a wait that walks the list and a
// releasing post also scan the waiter memory one entry at a time, set by its
// single read port. The result holds until transferred.
module named_semaphore_table_core #(
  parameter int SLOTS       = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int NAME_BYTES  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [63:0]        name_word,
  input  logic [3:0]         sem_slot,
  input  logic [5:0]         task_id,
  input  logic [15:0]        initial_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         slot_out,
  output logic [2:0]         status,
  output logic               caller_blocks,
  output logic               wake_valid,
  output logic [5:0]         wake_task,
  output logic signed [16:0] count_now
);
  import nst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  nst_dp #(.SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH), .NAME_BYTES(NAME_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .kind(kind), .name_word(name_word), .sem_slot(sem_slot), .task_id(task_id),
    .initial_value(initial_value), .slot_out(slot_out), .status(status),
    .caller_blocks(caller_blocks), .wake_valid(wake_valid), .wake_task(wake_task),
    .count_now(count_now)
  );
endmodule

// ===== sim/tb_named_semaphore_table_core.sv =====
// Self-checking testbench for named_semaphore_table_core.
// Depends on nst_pkg and the core; a behavioral copy of the semaphore table
// predicts every result, and a monitor compares each transfer in order.
module tb_named_semaphore_table_core;
  import nst_pkg::*;

  localparam int SLOTS = 16;
  localparam int QDEPTH = 16;
  localparam int NBYTES = 8;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] name_word;
    logic [3:0]  sem_slot;
    logic [5:0]  task_id;
    logic [15:0] initial_value;
  } req_t;

  typedef struct packed {
    logic [3:0]         slot_out;
    logic [2:0]         status;
    logic               caller_blocks;
    logic               wake_valid;
    logic [5:0]         wake_task;
    logic signed [16:0] count_now;
  } rsp_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [63:0] name_word = '0;
  logic [3:0] sem_slot = '0;
  logic [5:0] task_id = '0;
  logic [15:0] initial_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [3:0] slot_out;
  logic [2:0] status;
  logic caller_blocks;
  logic wake_valid;
  logic [5:0] wake_task;
  logic signed [16:0] count_now;

  named_semaphore_table_core dut (.*);

  // Predictor state.
  logic [63:0] sem_names [SLOTS];
  int          sem_counts [SLOTS];
  int          waiter_cnt [SLOTS];
  logic [5:0]  waiters [SLOTS][QDEPTH];

  req_t pending [$];
  rsp_t expected_rsp [$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int checked = 0;
  int total_items = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit stim_done = 0;
  logic [63:0] pool [8];

  initial forever #4 clk = ~clk;

  // Cuts the name at its first zero byte; returns 0 when empty or too long.
  function automatic bit trim_name(input logic [63:0] w, output logic [63:0] nm);
    bit ok;
    ok = 1;
    nm = '0;
    for (int i = 0; i < 8; i++) begin
      if (w[8*i +: 8] == 8'd0) break;
      if (i >= NBYTES) ok = 0;
      nm[8*i +: 8] = w[8*i +: 8];
    end
    return ok && nm != 0;
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    logic [63:0] nm;
    int s, c, nc, tot;
    bit listed;
    o = '0;
    s = -1;
    if (r.kind == KIND_OPEN || r.kind == KIND_UNLINK) begin
      if (!trim_name(r.name_word, nm)) begin
        o.status = ST_BAD_NAME;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (s < 0 && sem_names[i] != 0 && sem_names[i] == nm) s = i;
        if (r.kind == KIND_OPEN) begin
          if (s < 0) begin
            for (int i = 0; i < SLOTS; i++)
              if (s < 0 && sem_names[i] == 0) s = i;
            if (s < 0) o.status = ST_TABLE_FULL;
            else begin
              sem_names[s] = nm;
              sem_counts[s] = r.initial_value;
              waiter_cnt[s] = 0;
            end
          end
          if (s >= 0) begin
            o.slot_out = 4'(s);
            o.count_now = 17'(sem_counts[s]);
          end
        end else if (s < 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          sem_names[s] = 0;
          o.slot_out = 4'(s);
        end
      end
    end else if (sem_names[r.sem_slot] == 0) begin
      o.status = ST_NOT_FOUND;
      o.slot_out = r.sem_slot;
    end else begin
      s = r.sem_slot;
      c = sem_counts[s];
      tot = waiter_cnt[s];
      o.slot_out = 4'(s);
      if (r.kind == KIND_WAIT) begin
        nc = (c > -65536) ? c - 1 : c;
        if (nc < 0) begin
          listed = 0;
          for (int i = 0; i < tot; i++) if (waiters[s][i] == r.task_id) listed = 1;
          if (listed) begin
            c = nc;
            o.caller_blocks = 1;
          end else if (tot >= QDEPTH) begin
            o.status = ST_QUEUE_FULL;
          end else begin
            waiters[s][tot] = r.task_id;
            waiter_cnt[s] = tot + 1;
            c = nc;
            o.caller_blocks = 1;
          end
        end else begin
          c = nc;
        end
      end else begin
        if (c < 65535) c = c + 1;
        if (c <= 0 && tot > 0) begin
          o.wake_valid = 1;
          o.wake_task = waiters[s][0];
          waiters[s][0] = waiters[s][tot-1];
          waiter_cnt[s] = tot - 1;
        end
      end
      sem_counts[s] = c;
      o.count_now = 17'(c);
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch on %s: got %0h expected %0h (result %0d)", what, got, want,
             checked);
  endtask

  function automatic req_t mk(input logic [1:0] k, input logic [63:0] n,
                              input logic [3:0] s, input logic [5:0] t,
                              input logic [15:0] v);
    req_t r;
    r.kind = k;
    r.name_word = n;
    r.sem_slot = s;
    r.task_id = t;
    r.initial_value = v;
    return r;
  endfunction

  function automatic logic [63:0] rand_name();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: w = w & 64'h0000_0000_00FF_FFFF;
      1: w = w & 64'h0000_00FF_FFFF_FFFF;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    int n, sl;
    req_t r;
    // Directed: empty name, long names, full table, bad slots, saturation,
    // duplicate waiter, full queue, post with empty list, unlink with waiters.
    pending.push_back(mk(KIND_OPEN, 64'h0, 0, 0, 0));
    pending.push_back(mk(KIND_UNLINK, 64'h0000_0000_0000_FF00, 0, 0, 0));
    pending.push_back(mk(KIND_OPEN, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 16'hFFFF));
    pending.push_back(mk(KIND_POST, 0, 0, 0, 0));
    pending.push_back(mk(KIND_POST, 0, 0, 0, 0));
    pending.push_back(mk(KIND_OPEN, 64'h41, 0, 0, 0));
    pending.push_back(mk(KIND_WAIT, 0, 1, 6'h3F, 0));
    pending.push_back(mk(KIND_WAIT, 0, 1, 6'h3F, 0));
    for (int i = 0; i < 17; i++) pending.push_back(mk(KIND_WAIT, 0, 1, 6'(i), 0));
    pending.push_back(mk(KIND_POST, 0, 1, 0, 0));
    pending.push_back(mk(KIND_POST, 0, 15, 0, 0));
    pending.push_back(mk(KIND_UNLINK, 64'h99, 0, 0, 0));
    for (int i = 2; i < 17; i++)
      pending.push_back(mk(KIND_OPEN, 64'h100 + 64'(i), 0, 0, 16'(i)));
    pending.push_back(mk(KIND_UNLINK, 64'h41, 0, 0, 0));
    pending.push_back(mk(KIND_OPEN, 64'h41, 0, 0, 0));
    pending.push_back(mk(KIND_WAIT, 0, 1, 5, 0));
    for (int i = 0; i < 8; i++) pool[i] = rand_name();
    pool[0] = 64'h5A;
    n = 0;
    while (n < 900) begin
      sl = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0: r = mk(KIND_OPEN, pool[$urandom_range(0, 7)], 4'($urandom), 6'($urandom),
                  16'($urandom));
        1: r = mk(KIND_UNLINK, pool[$urandom_range(0, 7)], 4'($urandom), 6'($urandom),
                  16'($urandom));
        2: r = mk(2'($urandom), rand_name(), 4'($urandom), 6'($urandom), 16'($urandom));
        3, 4, 5: r = mk(KIND_WAIT, 64'($urandom), 4'(sl), 6'($urandom_range(0, 20)),
                        16'($urandom));
        default: r = mk(KIND_POST, 64'($urandom), 4'(sl), 6'($urandom), 16'($urandom));
      endcase
      if ($urandom_range(0, 30) == 0) pool[$urandom_range(0, 7)] = rand_name();
      pending.push_back(r);
      n++;
    end
    total_items = pending.size();
    stim_done = 1;
  end

  // Request driver: bursts with random gaps.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 8) rst <= 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_rsp.push_back(apply_request({kind, name_word, sem_slot, task_id,
                                              initial_value}));
        accepted <= accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 0;
        end else if (pending.size() > 0) begin
          r_drive(pending.pop_front());
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  task automatic r_drive(input req_t r);
    in_valid <= 1;
    kind <= r.kind;
    name_word <= r.name_word;
    sem_slot <= r.sem_slot;
    task_id <= r.task_id;
    initial_value <= r.initial_value;
  endtask

  // Result monitor; stall is held off in every third window of the cycle count and random otherwise.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      out_stall <= ((cycles / 64) % 3 == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(slot_out), '0);
        end else begin
          e = expected_rsp.pop_front();
          if (slot_out !== e.slot_out)
            report_mismatch("slot_out", 32'(slot_out), 32'(e.slot_out));
          if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
          if (caller_blocks !== e.caller_blocks)
            report_mismatch("caller_blocks", 32'(caller_blocks), 32'(e.caller_blocks));
          if (wake_valid !== e.wake_valid)
            report_mismatch("wake_valid", 32'(wake_valid), 32'(e.wake_valid));
          if (wake_task !== e.wake_task)
            report_mismatch("wake_task", 32'(wake_task), 32'(e.wake_task));
          if (count_now !== e.count_now)
            report_mismatch("count_now", 32'(count_now), 32'(e.count_now));
        end
        checked <= checked + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sem_names[i] = 0;
      sem_counts[i] = 0;
      waiter_cnt[i] = 0;
    end
    wait (stim_done);
    while (checked < total_items && cycles < LIMIT)
      @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("timeout with %0d results outstanding", expected_rsp.size());
      $display("tb_named_semaphore_table_core failed");
      $finish;
    end else begin
      repeat (40) @(posedge clk);
      $display("%0d requests sent, %0d results compared across open, wait, post, unlink",
               accepted, checked);
      if (errors == 0 && expected_rsp.size() == 0)
        $display("tb_named_semaphore_table_core passed");
      else
        $display("tb_named_semaphore_table_core failed");
      $finish;
    end
  end

endmodule
